FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the wavelength interpolator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/ptwi_pkg.sv
// Shared constants, types and the channel-to-slot decode of the interpolator.
// No dependencies.
package ptwi_pkg;

  localparam int TABLE_DEPTH  = 16384;
  localparam int X_FRAC_BITS  = 8;
  localparam int NUM_CHANNELS = 6;

  localparam int WORD_W       = 32;
  localparam int CH_W         = 3;
  localparam int X_W          = 23;
  localparam int IDX_FIELD_W  = 14;
  localparam int LEN_W        = 15;
  localparam int NUM_LEN_REGS = 6;
  localparam int CFG_IDX_W    = 3;

  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int ROW_W      = (IDX_W > 1) ? IDX_W - 1 : 1;
  localparam int ROWS       = TABLE_DEPTH / 2;
  localparam int BANK_DEPTH = NUM_CHANNELS * ROWS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int XL_W       = X_W - 1 - X_FRAC_BITS;
  localparam int SLOT_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int WEIGHT_W   = X_FRAC_BITS + 1;
  localparam int PROD_W     = WORD_W + WEIGHT_W;
  localparam int SUM_W      = PROD_W + 1;

  localparam int S_TDATA_W = ((CH_W + X_W + IDX_FIELD_W + WORD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((WORD_W + CH_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] LEN_RESET  = 15'd16384;
  localparam logic [CH_W-1:0]  CH_NONE    = 3'd0;
  localparam logic [CH_W-1:0]  CH_PINHOLE = 3'd4;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } slot_t;

  // Stage after the table read
  typedef struct packed {
    logic                   ok;
    logic [CH_W-1:0]        ch_out;
    logic [X_FRAC_BITS-1:0] frac;
    logic                   low_odd;
  } st1_t;

  // Stage after the multiplies
  typedef struct packed {
    logic              ok;
    logic [CH_W-1:0]   ch_out;
    logic [PROD_W-1:0] p_lo;
    logic [PROD_W-1:0] p_hi;
  } st2_t;

  // Channels 1-3 map to slots 0-2, channels 5-7 to slots 3-5; 0 and pinhole miss.
  function automatic slot_t slot_of(logic [CH_W-1:0] ch);
    logic [CH_W-1:0] s;
    slot_t           r;
    s = (ch < CH_PINHOLE) ? ch - CH_W'(1) : ch - CH_W'(2);
    r.hit  = (ch != CH_NONE) && (ch != CH_PINHOLE) && (32'(s) < NUM_CHANNELS);
    r.slot = s[SLOT_W-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/ptwi_bank.sv
// One bank of the calibration table: one write port, one registered read port.
// Depends on ptwi_pkg.
module ptwi_bank import ptwi_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [BANK_AW-1:0] wr_addr,
  input  logic [WORD_W-1:0]  wr_data,
  input  logic               rd_en,
  input  logic [BANK_AW-1:0] rd_addr,
  output logic [WORD_W-1:0]  rd_data
);

  logic [WORD_W-1:0] mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/pixel_to_wavelength_interpolator.sv
// Top level: length registers, even/odd table banks and the three-stage blend pipeline.
// Depends on ptwi_pkg, ptwi_bank and assert_macros.svh.
//
//  channel  direction  handshake            carries
//  s_*      in         s_tvalid / s_tready  event or table load request
//  m_*      out        m_tvalid / m_tready  wavelength result, one per request
//  cfg_*    in         cfg_valid/cfg_ready  length register write (ready out of reset)
//
// One request per cycle while m_tready keeps the output moving; a result passes st1, st2 and the output register.
// Entries xl and xl+1 always differ in parity, so the even and odd banks each
// serve one of the two reads in the same cycle; loads write at acceptance.
// Reset (rst, synchronous) clears the pipeline and sets all lengths to 16384;
// table contents are undefined until loaded, so there is no clearing pass.
// A stalled output holds; upstream stages keep filling bubbles until all are full.
`include "assert_macros.svh"

module pixel_to_wavelength_interpolator import ptwi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [2:0] channel, [25:3] x_position, [39:26] table_index, [71:40] table_value
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // [0] operation
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] wavelength, [34:32] channel_out, rest zero
  output logic [M_TDATA_W-1:0]  m_tdata,
  // [0] wavelength_valid
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LEN_W-1:0]      cfg_data
);

  logic [LEN_W-1:0] lengths [NUM_LEN_REGS];

  logic v1, v2, vo;
  logic en1, en2, en_o;
  logic s_acc;

  op_t                    in_op;
  logic [CH_W-1:0]        in_ch;
  logic [X_W-1:0]         in_x;
  logic [IDX_FIELD_W-1:0] in_idx;
  logic [WORD_W-1:0]      in_val;

  slot_t                  sl;
  logic [XL_W-1:0]        xl;
  logic [XL_W:0]          xu;
  logic [X_FRAC_BITS-1:0] frac;
  logic [LEN_W-1:0]       len_sel;
  logic [LEN_W-1:0]       eff_len;
  logic                   in_range;
  logic [ROW_W-1:0]       row_lo;
  logic [ROW_W-1:0]       row_even;
  logic [ROW_W-1:0]       ld_row;
  logic                   ld_ok;

  logic                   wr_even, wr_odd;
  logic [BANK_AW-1:0]     wr_addr, rd_addr_even, rd_addr_odd;
  logic [WORD_W-1:0]      rd_even, rd_odd;

  st1_t                   st1, st1_next;
  st2_t                   st2, st2_next;
  logic [WORD_W-1:0]      wl, wu;
  logic [WEIGHT_W-1:0]    weight;
  logic [SUM_W-1:0]       sum;

  logic                   o_ok;
  logic [CH_W-1:0]        o_ch;
  logic [WORD_W-1:0]      o_wave;

  // ---- handshake and bubble-collapsing pipeline control
  assign en_o     = !vo || m_tready;
  assign en2      = !v2 || en_o;
  assign en1      = !v1 || en2;
  assign s_tready = en1 && !rst;
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = vo;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_tvalid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en_o) begin
        vo <= v2;
      end
    end
  end

  // ---- length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEN_REGS; i++) begin
        lengths[i] <= LEN_RESET;
      end
    end else if (cfg_valid && cfg_ready && (32'(cfg_index) < NUM_LEN_REGS)) begin
      lengths[cfg_index] <= cfg_data;
    end
  end

  // ---- request decode, range check and bank addressing
  assign in_op  = op_t'(s_tuser);
  assign in_ch  = s_tdata[CH_W-1:0];
  assign in_x   = s_tdata[CH_W+X_W-1:CH_W];
  assign in_idx = s_tdata[CH_W+X_W+IDX_FIELD_W-1:CH_W+X_W];
  assign in_val = s_tdata[CH_W+X_W+IDX_FIELD_W+WORD_W-1:CH_W+X_W+IDX_FIELD_W];

  always_comb begin
    sl       = slot_of(in_ch);
    xl       = in_x[X_W-2:X_FRAC_BITS];
    frac     = in_x[X_FRAC_BITS-1:0];
    xu       = {1'b0, xl} + (XL_W+1)'(frac != '0);
    len_sel  = sl.hit ? lengths[sl.slot] : '0;
    eff_len  = (32'(len_sel) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH) : len_sel;
    in_range = !in_x[X_W-1] && (32'(xu) < 32'(eff_len));

    // Even bank holds the even neighbor: xl itself, or xl+1 when xl is odd.
    // The wrapped row past the end is only read when the fraction is zero.
    row_lo   = ROW_W'(xl[IDX_W-1:1]);
    row_even = xl[0] ? row_lo + ROW_W'(1) : row_lo;
    ld_row   = ROW_W'(in_idx[IDX_W-1:1]);
    ld_ok    = sl.hit && (32'(in_idx) < TABLE_DEPTH);

    st1_next.ok      = (in_op == OP_CONVERT) && sl.hit && in_range;
    st1_next.frac    = frac;
    st1_next.low_odd = xl[0];
    if (in_op == OP_LOAD) begin
      st1_next.ch_out = CH_NONE;
    end else if (!sl.hit || in_range) begin
      st1_next.ch_out = in_ch;
    end else begin
      st1_next.ch_out = CH_NONE;
    end
  end

  assign wr_addr      = BANK_AW'(int'(sl.slot) * ROWS + int'(ld_row));
  assign rd_addr_even = BANK_AW'(int'(sl.slot) * ROWS + int'(row_even));
  assign rd_addr_odd  = BANK_AW'(int'(sl.slot) * ROWS + int'(row_lo));
  assign wr_even      = s_acc && (in_op == OP_LOAD) && ld_ok && !in_idx[0];
  assign wr_odd       = s_acc && (in_op == OP_LOAD) && ld_ok && in_idx[0];

  ptwi_bank u_bank_even (
    .clk     (clk),
    .wr_en   (wr_even),
    .wr_addr (wr_addr),
    .wr_data (in_val),
    .rd_en   (en1),
    .rd_addr (rd_addr_even),
    .rd_data (rd_even)
  );

  ptwi_bank u_bank_odd (
    .clk     (clk),
    .wr_en   (wr_odd),
    .wr_addr (wr_addr),
    .wr_data (in_val),
    .rd_en   (en1),
    .rd_addr (rd_addr_odd),
    .rd_data (rd_odd)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      st1 <= st1_next;
    end
  end

  // ---- weights and products
  always_comb begin
    wl     = st1.low_odd ? rd_odd : rd_even;
    wu     = st1.low_odd ? rd_even : rd_odd;
    weight = WEIGHT_W'(1 << X_FRAC_BITS) - WEIGHT_W'(st1.frac);

    st2_next.ok     = st1.ok;
    st2_next.ch_out = st1.ch_out;
    st2_next.p_lo   = PROD_W'(wl) * PROD_W'(weight);
    // Drop the upper neighbor on an exact position; it may lie past the table.
    if (st1.frac == '0) begin
      st2_next.p_hi = '0;
    end else begin
      st2_next.p_hi = PROD_W'(wu) * PROD_W'(st1.frac);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      st2 <= st2_next;
    end
  end

  // ---- sum, truncate and output register
  assign sum = SUM_W'(st2.p_lo) + SUM_W'(st2.p_hi);

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_ok   <= st2.ok;
      o_ch   <= st2.ch_out;
      o_wave <= st2.ok ? sum[X_FRAC_BITS+WORD_W-1:X_FRAC_BITS] : '0;
    end
  end

  assign m_tdata = {(M_TDATA_W-WORD_W-CH_W)'(0), o_ch, o_wave};
  assign m_tuser = o_ok;

  // ---- checks
  `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst, !s_tready, v1 && v2 && vo && !m_tready)
  `ASSERT_IMPLIES(a_valid_has_table, clk, rst, m_tvalid && m_tuser, (o_ch != CH_NONE) && (o_ch != CH_PINHOLE))
  `ASSERT_IMPLIES(a_invalid_is_zero, clk, rst, m_tvalid && !m_tuser, o_wave == '0)
  `ASSERT_NEXT(a_accept_fills, clk, rst, s_acc, v1)
  `ASSERT_NEXT(a_load_empty_result, clk, rst, s_acc && (s_tuser == OP_LOAD), !st1.ok && (st1.ch_out == CH_NONE))

endmodule

FILE: verif/pixel_to_wavelength_interpolator_tb.sv
// Self-checking bench for pixel_to_wavelength_interpolator: directed table rows, then random
// loads and conversions under several length settings, checked against an in-bench predictor.
// Depends on ptwi_pkg and the interpolator RTL.
module pixel_to_wavelength_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptwi_pkg::*;

  localparam int WIN_SPAN         = 48;
  localparam int TOP_FIRST        = TABLE_DEPTH - 8;
  localparam int RANDOM_PER_PHASE = 106;
  localparam int N_PHASES         = 6;
  localparam int N_DIRECTED       = 26;
  localparam int FRAC_ONE         = 1 << X_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEN_CH1 = 3'd0,
    REG_LEN_CH2 = 3'd1,
    REG_LEN_CH3 = 3'd2,
    REG_LEN_CH5 = 3'd3,
    REG_LEN_CH6 = 3'd4,
    REG_LEN_CH7 = 3'd5,
    REG_SPARE_6 = 3'd6,
    REG_SPARE_7 = 3'd7
  } len_reg_e;

  typedef struct packed {
    op_t                    op;
    logic [CH_W-1:0]        ch;
    logic [X_W-1:0]         x;
    logic [IDX_FIELD_W-1:0] idx;
    logic [WORD_W-1:0]      val;
  } request_t;

  typedef struct packed {
    logic [WORD_W-1:0] wl;
    logic              vld;
    logic [CH_W-1:0]   ch;
  } wl_result_t;

  typedef struct packed {
    request_t   req;
    logic       typed;
    wl_result_t res;
  } dir_row_t;

  localparam wl_result_t NO_WL = '0;

  // Rows with typed = 0 take their expectation from the predictor.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_LOAD,    3'd1, 23'd0,        14'd0,     32'h0001_0000}, 1'b1, NO_WL},
    '{'{OP_LOAD,    3'd1, 23'd0,        14'd1,     32'hFFFF_FFFF}, 1'b1, NO_WL},
    '{'{OP_LOAD,    3'd2, 23'h7FFFFF,   14'd0,     32'h0000_0000}, 1'b1, NO_WL},
    '{'{OP_LOAD,    3'd3, 23'd0,        14'd0,     32'h8000_0000}, 1'b1, NO_WL},
    '{'{OP_LOAD,    3'd5, 23'd0,        14'd0,     32'h0000_0001}, 1'b1, NO_WL},
    '{'{OP_LOAD,    3'd6, 23'd0,        14'd0,     32'h7FFF_FFFF}, 1'b1, NO_WL},
    '{'{OP_LOAD,    3'd7, 23'd0,        14'd16383, 32'h1234_5678}, 1'b1, NO_WL},
    '{'{OP_LOAD,    3'd7, 23'd0,        14'd16382, 32'hFFFF_FFFF}, 1'b1, NO_WL},
    '{'{OP_LOAD,    CH_NONE, 23'd0,     14'd5,     32'hDEAD_BEEF}, 1'b1, NO_WL},
    '{'{OP_LOAD,    CH_PINHOLE, 23'd0,  14'h3FFF,  32'hFFFF_FFFF}, 1'b1, NO_WL},
    '{'{OP_CONVERT, 3'd1, 23'h000000,   14'd0,     32'd0}, 1'b1,
      '{32'h0001_0000, 1'b1, 3'd1}},
    '{'{OP_CONVERT, 3'd1, 23'h000100,   14'd0,     32'd0}, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, 3'd1}},
    '{'{OP_CONVERT, 3'd1, 23'h000080,   14'd0,     32'd0}, 1'b0, NO_WL},
    '{'{OP_CONVERT, 3'd1, 23'h000001,   14'd0,     32'd0}, 1'b0, NO_WL},
    '{'{OP_CONVERT, 3'd1, 23'h0000FF,   14'd0,     32'd0}, 1'b0, NO_WL},
    '{'{OP_CONVERT, 3'd7, 23'd4194047,  14'd0,     32'd0}, 1'b0, NO_WL},
    '{'{OP_CONVERT, 3'd7, 23'd4194048,  14'd0,     32'd0}, 1'b1,
      '{32'h1234_5678, 1'b1, 3'd7}},
    '{'{OP_CONVERT, 3'd7, 23'd4194049,  14'd0,     32'd0}, 1'b1, NO_WL},
    '{'{OP_CONVERT, 3'd7, 23'h3FFFFF,   14'd0,     32'd0}, 1'b1, NO_WL},
    '{'{OP_CONVERT, 3'd1, 23'h7FFFFF,   14'd0,     32'd0}, 1'b1, NO_WL},
    '{'{OP_CONVERT, 3'd1, 23'h400000,   14'd0,     32'd0}, 1'b1, NO_WL},
    '{'{OP_CONVERT, CH_NONE, 23'd0,     14'd0,     32'd0}, 1'b1,
      '{32'd0, 1'b0, CH_NONE}},
    '{'{OP_CONVERT, CH_PINHOLE, 23'h000100, 14'd0, 32'd0}, 1'b1,
      '{32'd0, 1'b0, CH_PINHOLE}},
    '{'{OP_CONVERT, CH_PINHOLE, 23'h400000, 14'd0, 32'd0}, 1'b1,
      '{32'd0, 1'b0, CH_PINHOLE}},
    '{'{OP_CONVERT, 3'd2, 23'd0,        14'h3FFF,  32'hFFFF_FFFF}, 1'b1,
      '{32'h0000_0000, 1'b1, 3'd2}},
    '{'{OP_CONVERT, 3'd3, 23'd0,        14'd0,     32'd0}, 1'b1,
      '{32'h8000_0000, 1'b1, 3'd3}}
  };

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [LEN_W-1:0]       cfg_data  = '0;

  // Predictor state: its own copy of the tables, the written map and the lengths.
  logic [WORD_W-1:0] wave_mem [NUM_CHANNELS][TABLE_DEPTH];
  bit                loaded   [NUM_CHANNELS][TABLE_DEPTH];
  logic [LEN_W-1:0]  len_reg  [NUM_LEN_REGS] = '{default: LEN_RESET};

  wl_result_t expected_results [$];
  int         mismatches = 0;
  bit         calm       = 1'b0;
  int         rx_hold    = 0;

  pixel_to_wavelength_interpolator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int table_slot(logic [CH_W-1:0] ch);
    int s;
    case (ch) inside
      3'd1, 3'd2, 3'd3: s = int'(ch) - 1;
      3'd5, 3'd6, 3'd7: s = int'(ch) - 2;
      default:          s = -1;
    endcase
    return (s >= NUM_CHANNELS) ? -1 : s;
  endfunction

  function automatic logic [CH_W-1:0] slot_channel(int s);
    return (s < 3) ? CH_W'(s + 1) : CH_W'(s + 2);
  endfunction

  function automatic int effective_length(int s);
    if (s < 0) return 0;
    return (int'(len_reg[s]) > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_reg[s]);
  endfunction

  // Conversions that would read an entry nobody has loaded yet are never sent.
  function automatic bit touches_unwritten(request_t r);
    int s, xl, f;
    s = table_slot(r.ch);
    if (r.op == OP_LOAD || s < 0 || r.x[X_W-1]) return 1'b0;
    xl = int'(r.x) >> X_FRAC_BITS;
    f  = int'(r.x) & (FRAC_ONE - 1);
    if (xl + ((f != 0) ? 1 : 0) >= effective_length(s)) return 1'b0;
    return !loaded[s][xl] || (f != 0 && !loaded[s][xl + 1]);
  endfunction

  function automatic wl_result_t interpolate_request(request_t r);
    wl_result_t       res;
    int               s, xl, f, xu;
    longint unsigned  lo, hi;
    res = '0;
    s   = table_slot(r.ch);
    if (r.op == OP_LOAD) begin
      if (s >= 0 && int'(r.idx) < TABLE_DEPTH) begin
        wave_mem[s][r.idx] = r.val;
        loaded[s][r.idx]   = 1'b1;
      end
      return res;
    end
    if (s < 0) begin
      res.ch = r.ch;
      return res;
    end
    if (r.x[X_W-1]) return res;
    xl = int'(r.x) >> X_FRAC_BITS;
    f  = int'(r.x) & (FRAC_ONE - 1);
    xu = xl + ((f != 0) ? 1 : 0);
    if (xu >= effective_length(s)) return res;
    lo = wave_mem[s][xl];
    hi = (f != 0) ? wave_mem[s][xu] : 64'd0;
    res.wl  = WORD_W'((lo * longint'(FRAC_ONE - f) + hi * longint'(f)) >> X_FRAC_BITS);
    res.vld = 1'b1;
    res.ch  = r.ch;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick, xl, f;
    do begin
      r.idx = IDX_FIELD_W'($urandom);
      r.val = $urandom;
      r.x   = X_W'($urandom);
      if ($urandom_range(0, 99) < 85)
        r.ch = slot_channel($urandom_range(0, NUM_CHANNELS - 1));
      else
        r.ch = $urandom_range(0, 1) ? CH_NONE : CH_PINHOLE;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        r.op = OP_LOAD;
        pick = $urandom_range(0, 99);
        if (pick < 60)
          r.idx = IDX_FIELD_W'($urandom_range(0, WIN_SPAN - 1));
        else if (pick < 75)
          r.idx = IDX_FIELD_W'($urandom_range(TOP_FIRST, TABLE_DEPTH - 1));
        pick = $urandom_range(0, 19);
        if (pick == 0) r.val = '0;
        else if (pick == 1) r.val = '1;
      end else begin
        r.op = OP_CONVERT;
        f = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, FRAC_ONE - 1);
        if (pick < 70) begin
          if ($urandom_range(0, 4) == 0)
            xl = $urandom_range(TOP_FIRST, TABLE_DEPTH - 1);
          else
            xl = $urandom_range(0, WIN_SPAN - 1);
          r.x = X_W'((xl << X_FRAC_BITS) | f);
        end else if (pick < 82) begin
          // straddle the channel's length boundary
          xl = effective_length(table_slot(r.ch)) - 2 + $urandom_range(0, 2);
          if (xl < 0) xl = 0;
          if (xl > TABLE_DEPTH - 1) xl = TABLE_DEPTH - 1;
          r.x = X_W'((xl << X_FRAC_BITS) | f);
        end else if (pick < 90) begin
          r.x[X_W-1] = 1'b1;
        end
      end
    end while (touches_unwritten(r));
    return r;
  endfunction

  task automatic send_req(input request_t req, input bit typed, input wl_result_t typed_res);
    int         gap;
    wl_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {req.val, req.idx, req.x, req.ch};
    s_tuser  <= req.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = interpolate_request(req);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input len_reg_e which, input logic [LEN_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (int'(which) < NUM_LEN_REGS) len_reg[which] = value;
  endtask

  task automatic program_lengths(input int phase);
    logic [LEN_W-1:0] lens [NUM_LEN_REGS];
    case (phase)
      1: lens = '{default: LEN_RESET};
      2: lens = '{default: '0};
      3: lens = '{15'd1, 15'd2, 15'd3, 15'd17, 15'd40, 15'd48};
      4: lens = '{15'h7FFF, 15'd16383, 15'd16384, 15'd47, 15'd48, 15'd49};
      default: begin
        foreach (lens[r])
          lens[r] = ($urandom_range(0, 3) == 0) ? LEN_RESET
                                                : LEN_W'($urandom_range(0, WIN_SPAN + 2));
      end
    endcase
    foreach (lens[r]) write_length(len_reg_e'(r), lens[r]);
    if (phase == 4) begin
      // spare indexes must leave every length alone
      write_length(REG_SPARE_6, 15'h7FFF);
      write_length(REG_SPARE_7, 15'h0000);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: random stalls, none while calm.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      rx_hold  <= pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    wl_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request waiting: tdata %h tuser %b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[WORD_W-1:0] !== want.wl) begin
          $error("wavelength: expected %h, got %h", want.wl, m_tdata[WORD_W-1:0]);
          mismatches++;
        end
        if (m_tuser !== want.vld) begin
          $error("wavelength_valid: expected %b, got %b", want.vld, m_tuser);
          mismatches++;
        end
        if (m_tdata[WORD_W+CH_W-1:WORD_W] !== want.ch) begin
          $error("channel_out: expected %0d, got %0d", want.ch,
                 m_tdata[WORD_W+CH_W-1:WORD_W]);
          mismatches++;
        end
        if (m_tdata[M_TDATA_W-1:WORD_W+CH_W] !== '0) begin
          $error("tdata padding: expected 0, got %h", m_tdata[M_TDATA_W-1:WORD_W+CH_W]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    request_t req;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_req(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].res);

    // Load a low window and the top entries of every table before random conversions.
    for (int s = 0; s < NUM_CHANNELS; s++) begin
      for (int i = 0; i < WIN_SPAN + TABLE_DEPTH - TOP_FIRST; i++) begin
        req.op  = OP_LOAD;
        req.ch  = slot_channel(s);
        req.x   = X_W'($urandom);
        req.idx = IDX_FIELD_W'((i < WIN_SPAN) ? i : TOP_FIRST + i - WIN_SPAN);
        req.val = $urandom;
        send_req(req, 1'b1, NO_WL);
      end
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      if (phase > 0) begin
        stop_sending();
        wait_drained();
        program_lengths(phase);
      end
      calm = (phase == 1);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 3 && i == RANDOM_PER_PHASE / 2) begin
          // hold off until the pipeline is empty
          stop_sending();
          wait_drained();
        end
        send_req(random_request(), 1'b0, NO_WL);
      end
    end

    stop_sending();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
